[rtl/rft_pkg.sv]
// shared types and constants for the radial falloff texture pixel block
`timescale 1ns / 1ps

package rft_pkg;

  localparam int FRAC_W  = 16;
  localparam int HARD_W  = 17;
  localparam int DIST_W  = 17;
  localparam int ALPHA_W = 8;
  localparam int NUM_W   = 25;
  localparam int DEN_W   = 18;

  localparam logic [HARD_W-1:0]  Q_ONE      = 17'h10000;
  localparam logic [HARD_W-1:0]  HARD_RESET = 17'h08000;
  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'hFF;
  localparam logic [ALPHA_W-1:0] ALPHA_ZERO = 8'h00;

  typedef struct packed {
    logic outside;
    logic full;
  } flags_t;

endpackage

[rtl/radial_falloff_texture_pixel.sv]
// radial falloff texture pixel: alpha of a soft-edged round brush, one pixel per request.
// Takes one request per cycle while out_ready is high and returns one alpha per request in
// order. The root width is ROOT_W = clog2(TEXTURE_SIZE/2 + 1) + 16. The square root pipeline
// resolves one root bit per stage and is followed by the alpha divider at one bit per stage.
// Stages stall independently: a waiting result does not block new requests while any stage
// is empty.
// hardness is written through hardness_wr_en/hardness_wr_data and should change only while
// no request is in flight; values above 1.0 act as 1.0.
`timescale 1ns / 1ps

module radial_falloff_texture_pixel #(
  parameter int TEXTURE_SIZE = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          hardness_wr_en,
  input  logic [rft_pkg::HARD_W-1:0]    hardness_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    pixel_row,
  input  logic [7:0]                    pixel_col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rft_pkg::ALPHA_W-1:0]   alpha
);

  localparam int HALF    = TEXTURE_SIZE / 2;
  localparam int HALF_SQ = HALF * HALF;
  localparam int DX_W    = $clog2(HALF + 256) + 1;
  localparam int SQ_W    = 2 * DX_W;
  localparam int S_W     = SQ_W + 1;
  localparam int ROOT_W  = $clog2(HALF + 1) + rft_pkg::FRAC_W;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int FRAC2   = 2 * rft_pkg::FRAC_W;
  localparam int RAD_HI  = RAD_W - FRAC2;
  localparam int REC_K   = ROOT_W;
  localparam int REC_W   = REC_K + 1;
  localparam int PROD_W  = ROOT_W + REC_W;
  localparam int R_W     = ROOT_W + 1;
  localparam logic [REC_W-1:0] REC = REC_W'((64'd1 << REC_K) / HALF);

  logic [rft_pkg::HARD_W-1:0] hardness;
  logic [rft_pkg::HARD_W-1:0] h_eff;

  // stage a: squares
  logic                     a_valid, ready_a;
  logic [SQ_W-1:0]          a_sqx, a_sqy;
  logic signed [DX_W-1:0]   dx, dy;
  logic signed [SQ_W-1:0]   sqx, sqy;

  // stage b: radius test and radicand
  logic                     b_valid, ready_b;
  logic [RAD_W-1:0]         b_rad;
  rft_pkg::flags_t          b_flags;
  logic [S_W-1:0]           s_sum;
  logic                     s_out;

  // square root
  logic                     sq_in_ready, sq_valid;
  logic [ROOT_W-1:0]        sq_root;
  rft_pkg::flags_t          sq_flags;

  // stage c: reciprocal product
  logic                     c_valid, ready_c;
  logic [PROD_W-1:0]        c_prod;
  logic [ROOT_W-1:0]        c_root;
  rft_pkg::flags_t          c_flags;

  // stage d: quotient estimate and back product
  logic                       d_valid, ready_d;
  logic [rft_pkg::DIST_W-1:0] d_q;
  logic [R_W-1:0]             d_qc;
  logic [ROOT_W-1:0]          d_root;
  rft_pkg::flags_t            d_flags;
  logic [rft_pkg::DIST_W-1:0] q_est;

  // stage e: corrected distance
  logic                       e_valid, ready_e;
  logic [rft_pkg::DIST_W-1:0] e_dist;
  rft_pkg::flags_t            e_flags;
  logic [R_W-1:0]             rem_r;

  // stage f: divider operands
  logic                       f_valid, ready_f;
  logic [rft_pkg::NUM_W-1:0]  f_num;
  logic [rft_pkg::DEN_W-1:0]  f_den;
  rft_pkg::flags_t            f_flags;
  logic [rft_pkg::DIST_W-1:0] diff;
  logic [rft_pkg::HARD_W-1:0] den1;
  logic [rft_pkg::NUM_W-1:0]  num255;

  // divider
  logic                        dv_in_ready, dv_valid;
  logic [rft_pkg::ALPHA_W-1:0] dv_quo;
  rft_pkg::flags_t             dv_flags;

  logic ready_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      hardness <= rft_pkg::HARD_RESET;
    end else if (hardness_wr_en) begin
      hardness <= hardness_wr_data;
    end
  end

  assign h_eff = (hardness > rft_pkg::Q_ONE) ? rft_pkg::Q_ONE : hardness;

  // ready chain
  assign ready_g  = !out_valid || out_ready;
  assign ready_f  = !f_valid || dv_in_ready;
  assign ready_e  = !e_valid || ready_f;
  assign ready_d  = !d_valid || ready_e;
  assign ready_c  = !c_valid || ready_d;
  assign ready_b  = !b_valid || sq_in_ready;
  assign ready_a  = !a_valid || ready_b;
  assign in_ready = ready_a;

  // stage a
  always_comb begin
    dx  = $signed(DX_W'(pixel_col)) - $signed(DX_W'(HALF));
    dy  = $signed(DX_W'(pixel_row)) - $signed(DX_W'(HALF));
    sqx = SQ_W'(dx) * SQ_W'(dx);
    sqy = SQ_W'(dy) * SQ_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (ready_a) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      a_sqx <= sqx;
      a_sqy <= sqy;
    end
  end

  // stage b
  assign s_sum = S_W'(a_sqx) + S_W'(a_sqy);
  assign s_out = s_sum > S_W'(HALF_SQ);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (ready_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && a_valid) begin
      b_rad           <= s_out ? '0 : {s_sum[RAD_HI-1:0], {FRAC2{1'b0}}};
      b_flags.outside <= s_out;
      b_flags.full    <= 1'b0;
    end
  end

  rft_isqrt #(
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (sq_in_ready),
    .rad       (b_rad),
    .in_flags  (b_flags),
    .out_valid (sq_valid),
    .out_ready (ready_c),
    .root      (sq_root),
    .out_flags (sq_flags)
  );

  // stage c: root times reciprocal of the half size
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (ready_c) begin
      c_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c && sq_valid) begin
      c_prod  <= PROD_W'(sq_root) * PROD_W'(REC);
      c_root  <= sq_root;
      c_flags <= sq_flags;
    end
  end

  // stage d: estimate is exact or one low
  assign q_est = c_prod[REC_K +: rft_pkg::DIST_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (ready_d) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_d && c_valid) begin
      d_q     <= q_est;
      d_qc    <= R_W'(q_est) * R_W'(HALF);
      d_root  <= c_root;
      d_flags <= c_flags;
    end
  end

  // stage e
  assign rem_r = R_W'(d_root) - d_qc;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (ready_e) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_e && d_valid) begin
      e_dist  <= d_q + rft_pkg::DIST_W'(rem_r >= R_W'(HALF));
      e_flags <= d_flags;
    end
  end

  // stage f: numerator 2*255*(1-dist) + den, divisor 2*den
  assign diff   = rft_pkg::Q_ONE - e_dist;
  assign den1   = rft_pkg::Q_ONE - h_eff;
  assign num255 = rft_pkg::NUM_W'(diff) * rft_pkg::NUM_W'(rft_pkg::ALPHA_FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (ready_f) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_f && e_valid) begin
      f_num           <= {num255[rft_pkg::NUM_W-2:0], 1'b0} + rft_pkg::NUM_W'(den1);
      f_den           <= {den1, 1'b0};
      f_flags.outside <= e_flags.outside;
      f_flags.full    <= (e_dist < h_eff) || (h_eff == rft_pkg::Q_ONE);
    end
  end

  rft_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (dv_in_ready),
    .num       (f_num),
    .den       (f_den),
    .in_flags  (f_flags),
    .out_valid (dv_valid),
    .out_ready (ready_g),
    .quo       (dv_quo),
    .out_flags (dv_flags)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_g) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_g && dv_valid) begin
      if (dv_flags.outside) begin
        alpha <= rft_pkg::ALPHA_ZERO;
      end else if (dv_flags.full) begin
        alpha <= rft_pkg::ALPHA_FULL;
      end else begin
        alpha <= dv_quo;
      end
    end
  end

`ifndef ASSERT_OFF
  a_rec_correction: assert property (@(posedge clk) disable iff (rst)
    d_valid |-> rem_r < R_W'(2 * HALF))
    else $error("reciprocal estimate off by more than one");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    e_valid |-> e_dist <= rft_pkg::Q_ONE)
    else $error("normalized distance above one");

  a_quo_fits: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !f_flags.outside && !f_flags.full) |-> f_num < {f_den, 8'h00})
    else $error("alpha quotient would exceed eight bits");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (dv_valid && ready_g && dv_flags.outside) |=> alpha == rft_pkg::ALPHA_ZERO)
    else $error("pixel outside circle gave nonzero alpha");
`endif

endmodule

[rtl/rft_isqrt.sv]
// pipelined integer square root, one root bit per register stage
`timescale 1ns / 1ps

module rft_isqrt #(
  parameter int ROOT_W = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2*ROOT_W-1:0]    rad,
  input  rft_pkg::flags_t        in_flags,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ROOT_W-1:0]      root,
  output rft_pkg::flags_t        out_flags
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;
  localparam int NST   = ROOT_W;

  logic                  v      [NST];
  logic                  rdy    [NST];
  logic [RAD_W-1:0]      rad_q  [NST];
  logic [REM_W-1:0]      rem_q  [NST];
  logic [ROOT_W-1:0]     root_q [NST];
  rft_pkg::flags_t       flg_q  [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [RAD_W-1:0]  p_rad;
    logic [REM_W-1:0]  p_rem;
    logic [ROOT_W-1:0] p_root;
    rft_pkg::flags_t   p_flg;
    logic              p_v;
    logic [REM_W-1:0]  rem_t;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign p_rad  = rad;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_flg  = in_flags;
      assign p_v    = in_valid;
    end else begin : g_next
      assign p_rad  = rad_q[k-1];
      assign p_rem  = rem_q[k-1];
      assign p_root = root_q[k-1];
      assign p_flg  = flg_q[k-1];
      assign p_v    = v[k-1];
    end

    if (k == NST - 1) begin : g_last_rdy
      assign rdy[k] = !v[k] || out_ready;
    end else begin : g_mid_rdy
      assign rdy[k] = !v[k] || rdy[k+1];
    end

    assign rem_t = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
    assign trial = {1'b0, p_root, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && p_v) begin
        rad_q[k]  <= {p_rad[RAD_W-3:0], 2'b00};
        rem_q[k]  <= ge ? rem_t - trial : rem_t;
        root_q[k] <= {p_root[ROOT_W-2:0], ge};
        flg_q[k]  <= p_flg;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NST-1];
  assign root      = root_q[NST-1];
  assign out_flags = flg_q[NST-1];

endmodule

[rtl/rft_div.sv]
// pipelined restoring divider, one quotient bit per register stage
`timescale 1ns / 1ps

module rft_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rft_pkg::NUM_W-1:0]     num,
  input  logic [rft_pkg::DEN_W-1:0]     den,
  input  rft_pkg::flags_t               in_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rft_pkg::ALPHA_W-1:0]   quo,
  output rft_pkg::flags_t               out_flags
);

  localparam int NST = rft_pkg::ALPHA_W;

  logic                          v     [NST];
  logic                          rdy   [NST];
  logic [rft_pkg::NUM_W-1:0]     rem_q [NST];
  logic [rft_pkg::DEN_W-1:0]     den_q [NST];
  logic [rft_pkg::ALPHA_W-1:0]   quo_q [NST];
  rft_pkg::flags_t               flg_q [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int SH = NST - 1 - k;
    logic [rft_pkg::NUM_W-1:0]   p_rem;
    logic [rft_pkg::DEN_W-1:0]   p_den;
    logic [rft_pkg::ALPHA_W-1:0] p_quo;
    rft_pkg::flags_t             p_flg;
    logic                        p_v;
    logic [rft_pkg::NUM_W-1:0]   dsh;
    logic                        ge;

    if (k == 0) begin : g_first
      assign p_rem = num;
      assign p_den = den;
      assign p_quo = '0;
      assign p_flg = in_flags;
      assign p_v   = in_valid;
    end else begin : g_next
      assign p_rem = rem_q[k-1];
      assign p_den = den_q[k-1];
      assign p_quo = quo_q[k-1];
      assign p_flg = flg_q[k-1];
      assign p_v   = v[k-1];
    end

    if (k == NST - 1) begin : g_last_rdy
      assign rdy[k] = !v[k] || out_ready;
    end else begin : g_mid_rdy
      assign rdy[k] = !v[k] || rdy[k+1];
    end

    assign dsh = rft_pkg::NUM_W'(p_den) << SH;
    assign ge  = p_rem >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && p_v) begin
        rem_q[k] <= ge ? p_rem - dsh : p_rem;
        den_q[k] <= p_den;
        quo_q[k] <= {p_quo[rft_pkg::ALPHA_W-2:0], ge};
        flg_q[k] <= p_flg;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NST-1];
  assign quo       = quo_q[NST-1];
  assign out_flags = flg_q[NST-1];

endmodule

[bench/testbench.sv]
// testbench for radial_falloff_texture_pixel: random and directed pixels checked against an alpha model
`timescale 1ns / 1ps

module testbench;

  localparam int  BRUSH_HALF   = 128;
  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  SETTLE       = 60;
  localparam int  PHASE_ITEMS  = 155;

  class alpha_tracker_t;
    logic [rft_pkg::HARD_W-1:0]  hardness;
    logic [rft_pkg::ALPHA_W-1:0] alpha_due[$];
    int                          errors;

    function new();
      hardness = rft_pkg::HARD_RESET;
      errors   = 0;
    endfunction

    function void set_hardness(logic [rft_pkg::HARD_W-1:0] value);
      hardness = value;
    endfunction

    // floor of the square root, bit by bit from the top
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 23; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function logic [rft_pkg::ALPHA_W-1:0] brush_alpha(logic [7:0] row, logic [7:0] col);
      int              dx;
      int              dy;
      longint unsigned sq;
      longint unsigned norm_dist;
      longint unsigned h;
      longint unsigned num;
      longint unsigned den;
      longint unsigned a;
      dx = int'(col) - BRUSH_HALF;
      dy = int'(row) - BRUSH_HALF;
      sq = longint'(dx * dx + dy * dy);
      if (sq > BRUSH_HALF * BRUSH_HALF) return rft_pkg::ALPHA_ZERO;
      norm_dist = root_floor(sq << 32) / BRUSH_HALF;
      if (norm_dist > rft_pkg::Q_ONE) norm_dist = 64'(rft_pkg::Q_ONE);
      h = (hardness > rft_pkg::Q_ONE) ? 64'(rft_pkg::Q_ONE) : 64'(hardness);
      if (h >= rft_pkg::Q_ONE || norm_dist < h) return rft_pkg::ALPHA_FULL;
      num = 255 * (rft_pkg::Q_ONE - norm_dist);
      den = rft_pkg::Q_ONE - h;
      a = (2 * num + den) / (2 * den);
      if (a > 255) a = 255;
      return a[rft_pkg::ALPHA_W-1:0];
    endfunction

    function void note_request(logic [7:0] row, logic [7:0] col);
      alpha_due.push_back(brush_alpha(row, col));
    endfunction

    function void check_alpha(logic [rft_pkg::ALPHA_W-1:0] got);
      logic [rft_pkg::ALPHA_W-1:0] want;
      if (alpha_due.size() == 0) begin
        $error("alpha: unexpected result %0d", got);
        errors++;
        return;
      end
      want = alpha_due.pop_front();
      if (got !== want) begin
        $error("alpha: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return alpha_due.size();
    endfunction

    function void close_out();
      if (alpha_due.size() != 0) begin
        $error("alpha: %0d results never arrived", alpha_due.size());
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         hardness_wr_en = 1'b0;
  logic [rft_pkg::HARD_W-1:0]   hardness_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [7:0]                   pixel_row = '0;
  logic [7:0]                   pixel_col = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [rft_pkg::ALPHA_W-1:0]  alpha;

  int                  cycle_count = 0;
  logic                steady = 1'b0;
  alpha_tracker_t      tracker = new();

  radial_falloff_texture_pixel dut (
    .clk              (clk),
    .rst              (rst),
    .hardness_wr_en   (hardness_wr_en),
    .hardness_wr_data (hardness_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .pixel_row        (pixel_row),
    .pixel_col        (pixel_col),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .alpha            (alpha)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_request(pixel_row, pixel_col);
      if (out_valid && out_ready) tracker.check_alpha(alpha);
    end
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 22);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("testbench: done, errors");
    $finish;
  end

  // called and returns at a falling edge
  task automatic send_pixel(input logic [7:0] row, input logic [7:0] col);
    while (!steady && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    pixel_row <= row;
    pixel_col <= col;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  task automatic write_hardness(input logic [rft_pkg::HARD_W-1:0] value);
    hardness_wr_en   <= 1'b1;
    hardness_wr_data <= value;
    @(negedge clk);
    hardness_wr_en   <= 1'b0;
    tracker.set_hardness(value);
  endtask

  // mostly anywhere, some on the axes where squares land exactly
  task automatic send_random_pixel();
    logic [7:0] row;
    logic [7:0] col;
    row = 8'($urandom_range(0, 255));
    col = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: row = 8'(BRUSH_HALF);
      1: col = 8'(BRUSH_HALF);
      default: ;
    endcase
    send_pixel(row, col);
  endtask

  initial begin
    logic [rft_pkg::HARD_W-1:0] phase_hardness[11];

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // center, corners, rim, inner edge at reset hardness
    send_pixel(8'd128, 8'd128);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd0, 8'd128);
    send_pixel(8'd128, 8'd0);
    send_pixel(8'd255, 8'd128);
    send_pixel(8'd128, 8'd255);
    send_pixel(8'd128, 8'd192);
    send_pixel(8'd128, 8'd191);
    send_pixel(8'd128, 8'd193);
    send_pixel(8'd37, 8'd37);
    send_pixel(8'd38, 8'd38);
    wait_drained();

    // hardness of one: full strength out to the rim
    write_hardness(rft_pkg::Q_ONE);
    send_pixel(8'd0, 8'd128);
    send_pixel(8'd128, 8'd128);
    send_pixel(8'd128, 8'd255);
    send_pixel(8'd37, 8'd37);
    wait_drained();

    // above one acts as one
    write_hardness('1);
    send_pixel(8'd128, 8'd0);
    send_pixel(8'd200, 8'd60);
    wait_drained();

    write_hardness('0);
    send_pixel(8'd128, 8'd128);
    send_pixel(8'd128, 8'd129);
    send_pixel(8'd0, 8'd128);
    wait_drained();

    phase_hardness[0]  = '0;
    phase_hardness[1]  = 17'd1;
    phase_hardness[2]  = rft_pkg::Q_ONE - 17'd1;
    phase_hardness[3]  = rft_pkg::HARD_RESET;
    phase_hardness[4]  = rft_pkg::Q_ONE;
    phase_hardness[5]  = '1;
    phase_hardness[6]  = 17'd98304;
    phase_hardness[7]  = rft_pkg::HARD_W'($urandom_range(0, 131071));
    phase_hardness[8]  = rft_pkg::HARD_W'($urandom_range(0, 65536));
    phase_hardness[9]  = rft_pkg::HARD_W'($urandom_range(0, 65536));
    phase_hardness[10] = rft_pkg::HARD_W'($urandom_range(0, 131071));

    for (int p = 0; p < 11; p++) begin
      write_hardness(phase_hardness[p]);
      steady = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == PHASE_ITEMS / 2) wait_drained();
        send_random_pixel();
      end
      wait_drained();
      steady = 1'b0;
    end

    repeat (SETTLE) @(negedge clk);
    tracker.close_out();
    if (tracker.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
